[rtl/crtb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the CRT beam sync timing unit.
// No dependencies; imported by every module of the block.
package crtb_pkg;

   localparam int unsigned LineCharsW   = 6;
   localparam int unsigned HtraceLenW   = 6;
   localparam int unsigned ActiveLinesW = 9;
   localparam int unsigned VtraceLenW   = 12;
   localparam int unsigned CsrIndexW    = 2;
   localparam int unsigned CsrDataW     = 12;
   localparam int unsigned ReqDataW     = 24;
   localparam int unsigned ReqUserW     = 2;
   localparam int unsigned RspDataW     = 40;
   localparam int unsigned RspUserW     = 2;

   localparam logic [9:0] PARK_Y   = 10'd311;
   localparam logic [5:0] PARK_COL = 6'd63;

   localparam logic [LineCharsW-1:0]   LINE_CHARS_RST   = 6'd52;
   localparam logic [HtraceLenW-1:0]   HTRACE_LEN_RST   = 6'd12;
   localparam logic [ActiveLinesW-1:0] ACTIVE_LINES_RST = 9'd288;
   localparam logic [VtraceLenW-1:0]   VTRACE_LEN_RST   = 12'd1536;

   typedef enum logic [CsrIndexW-1:0] {
      REG_LINE_CHARS   = 2'd0,
      REG_HTRACE_LEN   = 2'd1,
      REG_ACTIVE_LINES = 2'd2,
      REG_VTRACE_LEN   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [VtraceLenW-1:0]   vtrace_len;
      logic [ActiveLinesW-1:0] active_lines;
      logic [HtraceLenW-1:0]   htrace_len;
      logic [LineCharsW-1:0]   line_chars;
   } cfg_type;

   typedef struct packed {
      logic [5:0]  hretrace_left;
      logic        hretrace_on;
      logic [11:0] vretrace_left;
      logic        vretrace_on;
      logic [9:0]  scanline;
      logic [5:0]  position_counter;
      logic [1:0]  sync_seen;
      logic [5:0]  column_counter;
      logic [9:0]  line_counter;
   } beam_state_type;

   typedef struct packed {
      logic        hsync_level;
      logic        vsync_level;
      logic [13:0] mem_addr;
      logic [4:0]  row_addr;
   } tick_type;

   typedef struct packed {
      logic [RspUserW-1:0] user;
      logic [RspDataW-1:0] data;
   } rsp_word_type;

endpackage

[rtl/crt_beam_sync_timing_unit.sv]
`timescale 1ns / 1ps
// Top level of the CRT beam sync timing unit: configuration registers, beam
// state registers, tick logic and result buffer. Depends on crtb_pkg,
// crtb_beam_step and crtb_out_buf.
//
//  channel | dir | ports                             | transfer
//  req     | in  | req_tvalid/tready/tdata/tuser     | one character tick
//  rsp     | out | rsp_tvalid/tready/tdata/tuser     | one beam result per tick
//  csr     | in  | csr_valid/ready/index/data        | one register write
//
// One tick per cycle unless req stalls; each result is registered before it appears on rsp.
// The beam state registers, result register and skid stage are the only timing stages.
// Reset loads the register defaults and clears all counters and sync memory.
// A stalled rsp parks one result in the skid stage; req stalls while it is full.
module crt_beam_sync_timing_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [crtb_pkg::ReqDataW-1:0]  req_tdata,  // mem_addr[13:0], row_addr[18:14]
   input  logic [crtb_pkg::ReqUserW-1:0]  req_tuser,  // hsync_level[0], vsync_level[1]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // beam_x[6:0], beam_y[16:7], video_addr[32:17], beam_column[38:33]
   output logic [crtb_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [crtb_pkg::RspUserW-1:0]  rsp_tuser,  // h_retrace[0], v_retrace[1]
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crtb_pkg::CsrIndexW-1:0] csr_index,
   input  logic [crtb_pkg::CsrDataW-1:0]  csr_data
);
   import crtb_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   beam_state_type state_ff, state_in;
   beam_state_type step_state;
   tick_type       tick;
   rsp_word_type   step_word, out_word;
   logic           req_xfer;
   logic           skid_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_LINE_CHARS:   cfg_in.line_chars   = csr_data[LineCharsW-1:0];
            REG_HTRACE_LEN:   cfg_in.htrace_len   = csr_data[HtraceLenW-1:0];
            REG_ACTIVE_LINES: cfg_in.active_lines = csr_data[ActiveLinesW-1:0];
            REG_VTRACE_LEN:   cfg_in.vtrace_len   = csr_data[VtraceLenW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign tick.hsync_level = req_tuser[0];
   assign tick.vsync_level = req_tuser[1];
   assign tick.mem_addr    = req_tdata[13:0];
   assign tick.row_addr    = req_tdata[18:14];

   assign req_xfer = req_tvalid && req_tready;
   assign state_in = req_xfer ? step_state : state_ff;

   crtb_beam_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .tick (tick),
      .nxt  (step_state),
      .word (step_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_chars   <= LINE_CHARS_RST;
         cfg_ff.htrace_len   <= HTRACE_LEN_RST;
         cfg_ff.active_lines <= ACTIVE_LINES_RST;
         cfg_ff.vtrace_len   <= VTRACE_LEN_RST;
         state_ff            <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   crtb_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_word (step_word),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word),
      .skid_busy (skid_busy)
   );

   assign rsp_tdata = out_word.data;
   assign rsp_tuser = out_word.user;

   a_skid_needs_main : assert property (@(posedge clock) disable iff (reset)
      skid_busy |-> rsp_tvalid)
      else $error("skid stage holds a result while output register is empty");

   a_req_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   a_vpark : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[16:7] == PARK_Y))
      else $error("scanline not parked during vertical retrace");

   a_hpark : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[38:33] == PARK_COL))
      else $error("column not parked during horizontal retrace");

endmodule

[rtl/crtb_beam_step.sv]
`timescale 1ns / 1ps
// One character-clock tick of the beam: sync edges, retrace timing, line
// counting and the result word. Depends on crtb_pkg.
module crtb_beam_step (
   input  crtb_pkg::cfg_type        cfg,
   input  crtb_pkg::beam_state_type cur,
   input  crtb_pkg::tick_type       tick,
   output crtb_pkg::beam_state_type nxt,
   output crtb_pkg::rsp_word_type   word
);
   import crtb_pkg::*;

   beam_state_type s;
   logic [6:0]     beam_x;
   logic [15:0]    video_addr;

   always_comb begin
      s = cur;
      if (tick.hsync_level) begin
         if (!s.sync_seen[0]) begin
            s.sync_seen[0]   = 1'b1;
            s.column_counter = cfg.line_chars;
            s.hretrace_on    = 1'b1;
            s.hretrace_left  = cfg.htrace_len;
         end
      end else begin
         s.sync_seen[0] = 1'b0;
      end
      if (tick.vsync_level) begin
         if (!s.sync_seen[1]) begin
            s.sync_seen[1]   = 1'b1;
            s.line_counter   = {1'b0, cfg.active_lines};
            s.vretrace_on    = 1'b1;
            s.vretrace_left  = cfg.vtrace_len;
         end
      end else begin
         s.sync_seen[1] = 1'b0;
      end

      if (s.vretrace_on) begin
         s.vretrace_left = s.vretrace_left - 12'd1;
         if (s.vretrace_left == 12'd0) begin
            s.line_counter = 10'd0;
            s.vretrace_on  = 1'b0;
            s.scanline     = 10'h3FF;
         end
      end
      if (s.hretrace_on) begin
         s.hretrace_left = s.hretrace_left - 6'd1;
         if (s.hretrace_left == 6'd0) begin
            s.hretrace_on = 1'b0;
            if (s.line_counter == {1'b0, cfg.active_lines}) begin
               s.vretrace_on   = 1'b1;
               s.vretrace_left = cfg.vtrace_len;
            end
            s.line_counter   = s.line_counter + 10'd1;
            s.column_counter = 6'd0;
            s.scanline       = s.scanline + 10'd1;
         end
      end else begin
         s.position_counter = s.position_counter + 6'd1;
         s.column_counter   = s.column_counter + 6'd1;
         if (s.column_counter == cfg.line_chars) begin
            s.hretrace_on      = 1'b1;
            s.hretrace_left    = cfg.htrace_len;
            s.position_counter = 6'd0;
         end
      end
      if (s.vretrace_on) begin
         s.scanline = PARK_Y;
      end
      if (s.hretrace_on) begin
         s.position_counter = PARK_COL;
      end
   end

   assign nxt        = s;
   assign beam_x     = {1'b0, s.column_counter} - 7'd1;
   assign video_addr = {tick.mem_addr[13:12], tick.row_addr[2:0], tick.mem_addr[9:0], 1'b0};

   assign word.data = {1'b0, s.position_counter, video_addr, s.scanline, beam_x};
   assign word.user = {s.vretrace_on, s.hretrace_on};

endmodule

[rtl/crtb_out_buf.sv]
`timescale 1ns / 1ps
// Result register with a skid stage so the input side keeps moving while
// one result waits. Depends on crtb_pkg.
module crtb_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crtb_pkg::rsp_word_type push_word,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output crtb_pkg::rsp_word_type out_word,
   output logic                   skid_busy
);
   import crtb_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;
   assign skid_busy = skid_valid_ff;

endmodule
